// ----- hw/rtl/load_presence_cover_qualifier_defines.svh -----
// Assertion macros shared by the cover qualifier RTL
`ifndef LOAD_PRESENCE_COVER_QUALIFIER_DEFINES_SVH
`define LOAD_PRESENCE_COVER_QUALIFIER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LPCQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LPCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lpcq_pkg.sv -----
// Types and constants for the load presence cover qualifier
package lpcq_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int TIME_W       = 32;
  localparam int TARGET_W     = 23;
  localparam int FRAC_W       = 16;
  localparam int DELTA_W      = 16;
  localparam int LEVEL_W      = 24;
  localparam int COUNT_W      = 4;
  localparam int WINDOW_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [FRAC_W-1:0]   TOL_FRAC_RST  = FRAC_W'(6554);
  localparam logic [DELTA_W-1:0]  STABLE_RST    = DELTA_W'(10);
  localparam logic [LEVEL_W-1:0]  EMPTY_RST     = LEVEL_W'(100);
  localparam logic [COUNT_W-1:0]  CONFIRM_RST   = COUNT_W'(3);
  localparam logic [WINDOW_W-1:0] WINDOW_RST    = WINDOW_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_WEIGHT  = 3'd0,
    REG_TOLERANCE_FRAC = 3'd1,
    REG_STABLE_DELTA   = 3'd2,
    REG_EMPTY_LEVEL    = 3'd3,
    REG_CONFIRM_COUNT  = 3'd4,
    REG_WINDOW_MS      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2
  } cover_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          time_ms;
  } in_item_t;

  typedef struct packed {
    cover_cmd_t           cover_cmd;
    logic                 cover_is_open;
    logic [COUNT_W-1:0]   match_count;
  } out_item_t;

endpackage

// ----- hw/rtl/load_presence_cover_qualifier.sv -----
// Load presence cover qualifier: stability, band and empty checks with confirm count
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item_t  (sample, time_ms)
//   out_     output     out_valid/out_stall out_item_t (cover_cmd, cover_is_open, match_count)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ is not stalled; each result passes through
// the input register, then the result register.
// The tolerance band limits are registered products of the configuration registers.
// rst_n is synchronous; it clears valids, state and configuration to reset values.
// A stall on out_ backs up through the input register to in_stall in the same cycle.
module load_presence_cover_qualifier
  import lpcq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "load_presence_cover_qualifier_defines.svh"

  localparam int SPAN_W   = FRAC_W + 1;
  localparam int BAND_W   = TARGET_W + SPAN_W;
  localparam int SCALED_W = SAMPLE_W + FRAC_W;
  localparam int CMP_W    = ((SCALED_W > BAND_W) ? SCALED_W : BAND_W) + 1;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int LVL_CMP_W = (SAMPLE_W > LEVEL_W) ? SAMPLE_W : LEVEL_W;

  logic [TARGET_W-1:0]       target_r;
  logic [FRAC_W-1:0]         tol_r;
  logic [DELTA_W-1:0]        delta_r;
  logic signed [LEVEL_W-1:0] empty_r;
  logic [COUNT_W-1:0]        confirm_r;
  logic [WINDOW_W-1:0]       window_r;

  logic [BAND_W-1:0]         band_lo_r;
  logic [BAND_W-1:0]         band_hi_r;

  logic                      s1_valid_r;
  in_item_t                  s1_r;
  logic                      out_valid_r;
  out_item_t                 out_r;

  logic signed [SAMPLE_W-1:0] prev_r;
  logic [COUNT_W-1:0]         matches_r;
  logic [TIME_W-1:0]          first_time_r;
  logic                       armed_r;
  logic                       cover_open_r;

  logic signed [SAMPLE_W-1:0] prev_nxt;
  logic [COUNT_W-1:0]         matches_nxt;
  logic [TIME_W-1:0]          first_time_nxt;
  logic                       armed_nxt;
  logic                       cover_open_nxt;
  out_item_t                  out_nxt;

  logic                       out_free;
  logic                       s1_adv;
  logic                       in_acc;

  logic [SPAN_W-1:0]          span_lo;
  logic [SPAN_W-1:0]          span_hi;
  logic [TIME_W-1:0]          elapsed;
  logic                       window_clr;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          diff_abs;
  logic                       stable;
  logic signed [CMP_W-1:0]    scaled;
  logic signed [CMP_W-1:0]    lo_cmp;
  logic signed [CMP_W-1:0]    hi_cmp;
  logic                       in_band;
  logic                       is_empty;
  logic                       hit;
  logic [COUNT_W-1:0]         m_base;
  logic [COUNT_W-1:0]         m_inc;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= '0;
      tol_r     <= TOL_FRAC_RST;
      delta_r   <= STABLE_RST;
      empty_r   <= EMPTY_RST;
      confirm_r <= CONFIRM_RST;
      window_r  <= WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET_WEIGHT:  target_r  <= cfg_data[TARGET_W-1:0];
        REG_TOLERANCE_FRAC: tol_r     <= cfg_data[FRAC_W-1:0];
        REG_STABLE_DELTA:   delta_r   <= cfg_data[DELTA_W-1:0];
        REG_EMPTY_LEVEL:    empty_r   <= cfg_data[LEVEL_W-1:0];
        REG_CONFIRM_COUNT:  confirm_r <= cfg_data[COUNT_W-1:0];
        REG_WINDOW_MS:      window_r  <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // band limits: target * (1 -/+ tol), scaled by 2^16
  assign span_lo = (SPAN_W'(1) << FRAC_W) - SPAN_W'(tol_r);
  assign span_hi = (SPAN_W'(1) << FRAC_W) + SPAN_W'(tol_r);

  always_ff @(posedge clk) begin
    band_lo_r <= BAND_W'(target_r) * BAND_W'(span_lo);
    band_hi_r <= BAND_W'(target_r) * BAND_W'(span_hi);
  end

  always_comb begin
    elapsed    = s1_r.time_ms - first_time_r;
    window_clr = armed_r && (elapsed >= TIME_W'(window_r));

    diff     = DIFF_W'(s1_r.sample) - DIFF_W'(prev_r);
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    stable   = diff_abs < DIFF_W'(delta_r);

    scaled   = CMP_W'($signed({s1_r.sample, {FRAC_W{1'b0}}}));
    lo_cmp   = $signed(CMP_W'(band_lo_r));
    hi_cmp   = $signed(CMP_W'(band_hi_r));
    in_band  = (scaled >= lo_cmp) && (scaled <= hi_cmp);
    is_empty = LVL_CMP_W'(s1_r.sample) <= LVL_CMP_W'(empty_r);

    hit = stable && (cover_open_r ? is_empty : in_band);

    m_base = window_clr ? '0 : matches_r;
    m_inc  = m_base + COUNT_W'(1);

    matches_nxt    = m_base;
    first_time_nxt = first_time_r;
    armed_nxt      = armed_r;
    cover_open_nxt = cover_open_r;
    out_nxt.cover_cmd = CMD_NONE;

    if (hit) begin
      if (m_base == '0) begin
        first_time_nxt = s1_r.time_ms;
        armed_nxt      = 1'b1;
      end
      matches_nxt = m_inc;
      if (m_inc >= confirm_r) begin
        matches_nxt       = '0;
        cover_open_nxt    = !cover_open_r;
        out_nxt.cover_cmd = cover_open_r ? CMD_CLOSE : CMD_OPEN;
      end
    end

    prev_nxt              = s1_r.sample;
    out_nxt.cover_is_open = cover_open_nxt;
    out_nxt.match_count   = matches_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_r       <= '0;
      matches_r    <= '0;
      first_time_r <= '0;
      armed_r      <= 1'b0;
      cover_open_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        prev_r       <= prev_nxt;
        matches_r    <= matches_nxt;
        first_time_r <= first_time_nxt;
        armed_r      <= armed_nxt;
        cover_open_r <= cover_open_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  `LPCQ_ASSERT_NOW(a_open_cmd_state, out_valid_r && (out_r.cover_cmd == CMD_OPEN), out_r.cover_is_open, "open command with cover closed")
  `LPCQ_ASSERT_NOW(a_close_cmd_state, out_valid_r && (out_r.cover_cmd == CMD_CLOSE), !out_r.cover_is_open, "close command with cover open")
  `LPCQ_ASSERT_NOW(a_cmd_clears_count, out_valid_r && (out_r.cover_cmd != CMD_NONE), out_r.match_count == '0, "count not cleared on toggle")
  `LPCQ_ASSERT_NEXT(a_state_holds, !s1_adv, $stable(cover_open_r) && $stable(matches_r) && $stable(armed_r), "state moved without a retiring transaction")
  `LPCQ_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r, "input stalled with room available")

endmodule
